// ===== src/spas_pkg.sv =====
// Shared constants and codes for the shortest path array scan unit.
package spas_pkg;

    localparam int MAX_NODES_DEF   = 64;
    localparam int MAX_EDGES_DEF   = 256;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int ID_W     = 6;
    localparam int CNT_W    = 7;
    localparam int IN_WT_W  = 16;
    localparam int LEN_W    = 22;
    localparam int OPC_W    = 2;
    localparam int ERR_W    = 2;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

    localparam logic [OPC_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OPC_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OPC_W-1:0] OP_QUERY = 2'd2;
    localparam logic [OPC_W-1:0] OP_RSVD  = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_ID  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NO_PATH = 2'd2;

endpackage

// ===== src/shortest_path_array_scan_unit.sv =====
// Shortest path unit: edge store, array-scan Dijkstra sequencer and path output.
// Clear and add beats are taken in idle; the block stays idle for them.
// Query run time grows with the rounds R (R <= n = min(node_count, MAX_NODES)), the stored
//   edges E and the nodes P on the path; it is set by the single shared distance memory port
//   and the one-edge-at-a-time relax loop.
// in_stall is high for the whole query; a bad node id result is driven from S_ERR once the output is free.
// Reset clears control state, edge count and node_count (to 64); stores are not swept.
module shortest_path_array_scan_unit
    #(
    parameter int MAX_NODES   = spas_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES   = spas_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = spas_pkg::WEIGHT_BITS_DEF
    )
    (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_we,
    input  logic [spas_pkg::CNT_W-1:0]  cfg_data,
    // input beats
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [spas_pkg::OPC_W-1:0]  opcode,
    input  logic [spas_pkg::ID_W-1:0]   edge_from,
    input  logic [spas_pkg::ID_W-1:0]   edge_to,
    input  logic [spas_pkg::IN_WT_W-1:0] arc_weight,
    input  logic [spas_pkg::ID_W-1:0]   origin,
    input  logic [spas_pkg::ID_W-1:0]   destination,
    // result beats
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [spas_pkg::ID_W-1:0]   node_id,
    output logic [spas_pkg::LEN_W-1:0]  path_length,
    output logic                        last,
    output logic [spas_pkg::ERR_W-1:0]  error
    );

    import spas_pkg::*;

    // widths derived from the parameters
    localparam int NAW = $clog2(MAX_NODES);
    localparam int EW  = (WEIGHT_BITS < IN_WT_W) ? WEIGHT_BITS : IN_WT_W;
    localparam int DW  = EW + NAW + 1;                      // exact simple-path sums
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EDW = 2 * ID_W + EW;

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;   // array scan for the open minimum
    localparam logic [3:0] S_PICK  = 4'd2;   // close the winner, decide next step
    localparam logic [3:0] S_EADDR = 4'd3;   // edge store read in flight
    localparam logic [3:0] S_ECHK  = 4'd4;   // edge source/target check
    localparam logic [3:0] S_EUPD  = 4'd5;   // relax compare and write
    localparam logic [3:0] S_PATH  = 4'd6;   // push node on path stack
    localparam logic [3:0] S_PWAIT = 4'd7;   // predecessor read in flight
    localparam logic [3:0] S_EMRD  = 4'd8;   // stack read in flight
    localparam logic [3:0] S_EMPUT = 4'd9;   // hand path node to output
    localparam logic [3:0] S_ERR   = 4'd10;  // hand error result to output

    // stores
    logic [EDW-1:0]   edge_mem  [MAX_EDGES];
    logic [DW-1:0]    dist_mem  [MAX_NODES];
    logic [NAW-1:0]   pred_mem  [MAX_NODES];
    logic [NAW-1:0]   stack_mem [MAX_NODES];

    logic [EDW-1:0]   edge_q;
    logic [DW-1:0]    dist_q;
    logic [NAW-1:0]   pred_q;
    logic [NAW-1:0]   stack_q;

    // control and datapath registers
    logic [3:0]           state_reg,  state_next;
    logic [CNT_W-1:0]     ncount_reg;
    logic [ECW-1:0]       ecount_reg, ecount_next;
    logic [MAX_NODES-1:0] open_reg,   open_next;
    logic [MAX_NODES-1:0] reach_reg,  reach_next;
    logic [NAW-1:0]       org_reg,    org_next;
    logic [NAW-1:0]       dst_reg,    dst_next;
    logic [NCW-1:0]       scnt_reg,   scnt_next;
    logic                 svld_reg,   svld_next;
    logic [NAW-1:0]       sidx_reg,   sidx_next;
    logic                 found_reg,  found_next;
    logic [NAW-1:0]       sel_reg,    sel_next;
    logic [DW-1:0]        cd_reg,     cd_next;
    logic [ECW-1:0]       eidx_reg,   eidx_next;
    logic [NAW-1:0]       cur_reg,    cur_next;
    logic [NAW-1:0]       plen_reg,   plen_next;
    logic [NAW-1:0]       emidx_reg,  emidx_next;
    logic [ERR_W-1:0]     ecode_reg,  ecode_next;
    logic [DW-1:0]        total_reg,  total_next;

    logic                 ovld_reg,   ovld_next;
    logic [ID_W-1:0]      onode_reg,  onode_next;
    logic [LEN_W-1:0]     olen_reg,   olen_next;
    logic                 olast_reg,  olast_next;
    logic [ERR_W-1:0]     oerr_reg,   oerr_next;

    // memory port controls
    logic                 edge_we;
    logic [NAW-1:0]       dist_ra;
    logic                 dist_we;
    logic [NAW-1:0]       dist_wa;
    logic [DW-1:0]        dist_wd;
    logic                 pred_we;
    logic                 stack_we;

    logic [CNT_W-1:0]     nn;          // effective node count
    logic                 in_acc;
    logic                 out_free;
    logic [ID_W-1:0]      e_from, e_to;
    logic [EW-1:0]        e_wt;
    logic [NAW-1:0]       e_to_n;
    logic [DW-1:0]        pd;

    assign nn       = (ncount_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : ncount_reg;
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !ovld_reg || !out_stall;

    assign e_from = edge_q[EDW-1 -: ID_W];
    assign e_to   = edge_q[EW +: ID_W];
    assign e_wt   = edge_q[EW-1:0];
    assign e_to_n = e_to[NAW-1:0];
    assign pd     = cd_reg + DW'(e_wt);

    assign edge_we = in_acc && (opcode == OP_ADD) && (ecount_reg < ECW'(MAX_EDGES));

    // memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[ecount_reg[EAW-1:0]] <= {edge_from, edge_to, arc_weight[EW-1:0]};
        end
        edge_q <= edge_mem[eidx_reg[EAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_wa] <= dist_wd;
        end
        dist_q <= dist_mem[dist_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pred_we)
        begin
            pred_mem[e_to_n] <= sel_reg;
        end
        pred_q <= pred_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[plen_reg] <= cur_reg;
        end
        stack_q <= stack_mem[emidx_reg];
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        ecount_next = ecount_reg;
        open_next   = open_reg;
        reach_next  = reach_reg;
        org_next    = org_reg;
        dst_next    = dst_reg;
        scnt_next   = scnt_reg;
        svld_next   = 1'b0;
        sidx_next   = sidx_reg;
        found_next  = found_reg;
        sel_next    = sel_reg;
        cd_next     = cd_reg;
        eidx_next   = eidx_reg;
        cur_next    = cur_reg;
        plen_next   = plen_reg;
        emidx_next  = emidx_reg;
        ecode_next  = ecode_reg;
        total_next  = total_reg;

        ovld_next   = ovld_reg && out_stall;
        onode_next  = onode_reg;
        olen_next   = olen_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;

        dist_ra  = scnt_reg[NAW-1:0];
        dist_we  = 1'b0;
        dist_wa  = e_to_n;
        dist_wd  = pd;
        pred_we  = 1'b0;
        stack_we = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (opcode)
                        OP_CLEAR:
                        begin
                            ecount_next = '0;
                        end
                        OP_ADD:
                        begin
                            if (edge_we)
                            begin
                                ecount_next = ecount_reg + 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            if ((CNT_W'(origin) >= nn) || (CNT_W'(destination) >= nn))
                            begin
                                ecode_next = ERR_BAD_ID;
                                state_next = S_ERR;
                            end
                            else
                            begin
                                org_next   = origin[NAW-1:0];
                                dst_next   = destination[NAW-1:0];
                                open_next  = '0;
                                reach_next = '0;
                                open_next[origin[NAW-1:0]]  = 1'b1;
                                reach_next[origin[NAW-1:0]] = 1'b1;
                                dist_we    = 1'b1;
                                dist_wa    = origin[NAW-1:0];
                                dist_wd    = '0;
                                scnt_next  = '0;
                                found_next = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // unused opcode: no effect
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue one address per cycle, compare the one issued before
                if (CNT_W'(scnt_reg) < nn)
                begin
                    svld_next = 1'b1;
                    sidx_next = scnt_reg[NAW-1:0];
                    scnt_next = scnt_reg + 1'b1;
                end
                else if (!svld_reg)
                begin
                    state_next = S_PICK;
                end
                if (svld_reg && open_reg[sidx_reg] && (!found_reg || (dist_q < cd_reg)))
                begin
                    found_next = 1'b1;
                    sel_next   = sidx_reg;
                    cd_next    = dist_q;
                end
            end

            S_PICK:
            begin
                if (!found_reg)
                begin
                    ecode_next = ERR_NO_PATH;
                    state_next = S_ERR;
                end
                else
                begin
                    open_next[sel_reg] = 1'b0;
                    if (sel_reg == dst_reg)
                    begin
                        total_next = cd_reg;
                        cur_next   = dst_reg;
                        plen_next  = '0;
                        state_next = S_PATH;
                    end
                    else
                    begin
                        eidx_next  = '0;
                        state_next = S_EADDR;
                    end
                end
            end

            S_EADDR:
            begin
                if (eidx_reg == ecount_reg)
                begin
                    scnt_next  = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_ECHK;
                end
            end

            S_ECHK:
            begin
                dist_ra = e_to_n;
                if ((e_from == ID_W'(sel_reg)) && (CNT_W'(e_to) < nn))
                begin
                    state_next = S_EUPD;
                end
                else
                begin
                    eidx_next  = eidx_reg + 1'b1;
                    state_next = S_EADDR;
                end
            end

            S_EUPD:
            begin
                if (!reach_reg[e_to_n] || (pd < dist_q))
                begin
                    dist_we = 1'b1;
                    pred_we = 1'b1;
                    open_next[e_to_n]  = 1'b1;
                    reach_next[e_to_n] = 1'b1;
                end
                eidx_next  = eidx_reg + 1'b1;
                state_next = S_EADDR;
            end

            S_PATH:
            begin
                stack_we  = 1'b1;
                plen_next = plen_reg + 1'b1;
                if (cur_reg == org_reg)
                begin
                    emidx_next = plen_reg;
                    state_next = S_EMRD;
                end
                else
                begin
                    state_next = S_PWAIT;
                end
            end

            S_PWAIT:
            begin
                cur_next   = pred_q;
                state_next = S_PATH;
            end

            S_EMRD:
            begin
                state_next = S_EMPUT;
            end

            S_EMPUT:
            begin
                if (out_free)
                begin
                    ovld_next  = 1'b1;
                    onode_next = ID_W'(stack_q);
                    olen_next  = LEN_W'(total_reg);
                    olast_next = (emidx_reg == '0);
                    oerr_next  = ERR_NONE;
                    if (emidx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emidx_next = emidx_reg - 1'b1;
                        state_next = S_EMRD;
                    end
                end
            end

            S_ERR:
            begin
                if (out_free)
                begin
                    ovld_next  = 1'b1;
                    onode_next = '0;
                    olen_next  = '0;
                    olast_next = 1'b1;
                    oerr_next  = ecode_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ncount_reg <= NODE_COUNT_RST;
            ecount_reg <= '0;
            svld_reg   <= 1'b0;
            ovld_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ecount_reg <= ecount_next;
            svld_reg   <= svld_next;
            ovld_reg   <= ovld_next;
            if (cfg_we)
            begin
                ncount_reg <= cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        open_reg  <= open_next;
        reach_reg <= reach_next;
        org_reg   <= org_next;
        dst_reg   <= dst_next;
        scnt_reg  <= scnt_next;
        sidx_reg  <= sidx_next;
        found_reg <= found_next;
        sel_reg   <= sel_next;
        cd_reg    <= cd_next;
        eidx_reg  <= eidx_next;
        cur_reg   <= cur_next;
        plen_reg  <= plen_next;
        emidx_reg <= emidx_next;
        ecode_reg <= ecode_next;
        total_reg <= total_next;
        onode_reg <= onode_next;
        olen_reg  <= olen_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    assign out_valid   = ovld_reg;
    assign node_id     = onode_reg;
    assign path_length = olen_reg;
    assign last        = olast_reg;
    assign error       = oerr_reg;

endmodule

// ===== src/spas_checker.sv =====
// Port-level checker for the shortest path unit, bound to the top level.
module spas_checker
    (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [spas_pkg::OPC_W-1:0]   opcode,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [spas_pkg::ID_W-1:0]    node_id,
    input logic [spas_pkg::LEN_W-1:0]   path_length,
    input logic                         last,
    input logic [spas_pkg::ERR_W-1:0]   error
    );

    import spas_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(node_id) && $stable(path_length)
            && $stable(last) && $stable(error))
        else $error("result beat changed while stalled");

    // error beats are single, zeroed and final
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error != ERR_NONE) |-> last && (node_id == '0) && (path_length == '0))
        else $error("malformed error beat");

    // the unit only goes busy after taking a query
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid) && ($past(opcode) == OP_QUERY))
        else $error("busy without a query");

    // new results only come out of a running query
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat while idle");

endmodule

bind shortest_path_array_scan_unit spas_checker u_spas_checker
    (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .node_id     (node_id),
    .path_length (path_length),
    .last        (last),
    .error       (error)
    );
